// ===== rtl/core/cdq_pkg.sv =====
// cdq_pkg: shared types and constants for the circular deque.
// Holds the channel payload structs, command codes, sequencer states and
// controller-to-datapath command group. No dependencies.
package cdq_pkg;

  localparam int VAL_W   = 32;
  localparam int CMD_W   = 3;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 7;
  localparam int RESET_CAPACITY = 64;

  typedef enum logic [CMD_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_REAR  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_REAR  = 3'd3,
    OP_INQUIRE   = 3'd4
  } cdq_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CAPT
  } cdq_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    empty_res;
    logic                    full_res;
    logic [COUNT_W-1:0]      count;
  } cdq_out_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;      // apply the accepted item to pointers and store
    logic cfg_wr;    // take new capacity, empty the deque
    logic load_out;  // capture read data into the result register
  } cdq_cmd_t;

endpackage

// ===== rtl/core/circular_deque.sv =====
// circular_deque: top level of the bounded double-ended queue.
// Depends on cdq_pkg, cdq_ctrl, cdq_dpath (and cdq_ram through it).
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------
//  in      | in_valid / in_ready | in_data  (cdq_in_t)
//  out     | out_valid/out_ready | out_data (cdq_out_t)
//  cfg     | cfg_valid/cfg_ready | cfg_data (capacity_in_use)
//
// Each item passes through ST_IDLE, which moves a pointer and writes the
// entry, ST_READ for the registered read of front and rear from the store,
// and ST_CAPT to load the result register. The load waits while a previous
// result is still held; the next item is taken once the result is loaded.
// Reset (rst_n low, synchronous) empties the deque at capacity 64 clamped to
// DEPTH; the entry store needs no clearing pass. A capacity write also
// empties the deque.
module circular_deque #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cdq_pkg::cdq_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cdq_pkg::cdq_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cdq_pkg::CFG_W-1:0] cfg_data
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

// ===== rtl/core/cdq_ram.sv =====
// cdq_ram: generic RAM, one write port and two read ports, registered read.
// No package dependencies.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                     rdata_a,
  output logic [WIDTH-1:0]                     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/cdq_ctrl.sv =====
// cdq_ctrl: sequencer for the circular deque.
// Drives the handshakes and issues cdq_pkg::cdq_cmd_t to the datapath.
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  cdq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take new data this cycle
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !cfg_valid) state_nxt = ST_READ;
      end
      ST_READ: state_nxt = ST_CAPT;
      ST_CAPT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cfg_ready    = 1'b0;
    cmd.exec     = 1'b0;
    cmd.cfg_wr   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // configuration takes priority over an item in the same cycle
        cfg_ready  = 1'b1;
        in_ready   = !cfg_valid;
        cmd.cfg_wr = cfg_valid;
        cmd.exec   = in_valid && !cfg_valid;
      end
      ST_READ: ;
      ST_CAPT: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_READ))
    else $error("item accepted but sequencer did not move to read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  a_cfg_item_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_valid && cfg_ready && in_valid && in_ready))
    else $error("configuration and item accepted together");

endmodule

// ===== rtl/core/cdq_dpath.sv =====
// cdq_dpath: pointers, count, capacity, entry store and result register.
// Depends on cdq_pkg and cdq_ram; driven by cdq_ctrl commands.
module cdq_dpath #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cdq_pkg::cdq_cmd_t         cmd,
  input  cdq_pkg::cdq_in_t          in_data,
  input  logic [cdq_pkg::CFG_W-1:0] cfg_data,
  output cdq_pkg::cdq_out_t         out_data
);
  import cdq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W = $clog2(DEPTH + 1);
  localparam int RESET_CAP = (RESET_CAPACITY > DEPTH) ? DEPTH : RESET_CAPACITY;

  logic [CAP_W-1:0] cap_r, cap_nxt, cap_wr;
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt, last_ptr, last_wr;
  logic [CAP_W-1:0] count_r, count_nxt;
  logic             ok_r, ok_nxt;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [VAL_W-1:0] rdata_a, rdata_b;
  logic             empty, full;
  cdq_out_t         out_r;

  // clamp the written capacity into 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cap_wr = CAP_W'(1);
    end else if (32'(cfg_data) > 32'(DEPTH)) begin
      cap_wr = CAP_W'(DEPTH);
    end else begin
      cap_wr = CAP_W'(cfg_data);
    end
  end

  assign last_ptr = PTR_W'(cap_r - 1'b1);
  assign last_wr  = PTR_W'(cap_wr - 1'b1);
  assign empty    = (count_r == '0);
  assign full     = (count_r >= cap_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ok_nxt    = 1'b1;
    we        = 1'b0;
    waddr     = head_r;
    case (cdq_op_t'(in_data.cmd))
      OP_INS_FRONT: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          head_nxt  = (head_r == '0) ? last_ptr : head_r - 1'b1;
          we        = 1'b1;
          waddr     = head_nxt;
          count_nxt = count_r + 1'b1;
          if (empty) tail_nxt = head_nxt;
        end
      end
      OP_INS_REAR: begin
        if (full) begin
          ok_nxt = 1'b0;
        end else begin
          tail_nxt  = (tail_r == last_ptr) ? '0 : tail_r + 1'b1;
          we        = 1'b1;
          waddr     = tail_nxt;
          count_nxt = count_r + 1'b1;
          if (empty) head_nxt = tail_nxt;
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          ok_nxt = 1'b0;
        end else begin
          count_nxt = count_r - 1'b1;
          if (count_r == CAP_W'(1)) begin
            head_nxt = '0;
            tail_nxt = last_ptr;
          end else begin
            head_nxt = (head_r == last_ptr) ? '0 : head_r + 1'b1;
          end
        end
      end
      OP_DEL_REAR: begin
        if (empty) begin
          ok_nxt = 1'b0;
        end else begin
          count_nxt = count_r - 1'b1;
          if (count_r == CAP_W'(1)) begin
            head_nxt = '0;
            tail_nxt = last_ptr;
          end else begin
            tail_nxt = (tail_r == '0) ? last_ptr : tail_r - 1'b1;
          end
        end
      end
      default: ;  // inquire and unused codes: no change
    endcase
  end

  assign cap_nxt = cap_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_W'(RESET_CAP);
      head_r  <= '0;
      tail_r  <= PTR_W'(RESET_CAP - 1);
      count_r <= '0;
      ok_r    <= 1'b1;
    end else if (cmd.cfg_wr) begin
      cap_r   <= cap_nxt;
      head_r  <= '0;
      tail_r  <= last_wr;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ok_r    <= ok_nxt;
    end
  end

  cdq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (cmd.exec && we),
    .waddr   (waddr),
    .wdata   (in_data.value),
    .raddr_a (head_r),
    .raddr_b (tail_r),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // pointers settle at exec, so read data is current by the capture state
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.ok          <= ok_r;
      out_r.front_value <= empty ? '1 : rdata_a;
      out_r.rear_value  <= empty ? '1 : rdata_b;
      out_r.empty_res   <= empty;
      out_r.full_res    <= (count_r == cap_r);
      out_r.count       <= COUNT_W'(count_r);
    end
  end

  assign out_data = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("entry count above capacity");

  a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == '0 && tail_r == last_ptr))
    else $error("empty deque with pointers not at rest");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (32'(cap_r) <= 32'(DEPTH)))
    else $error("capacity out of range");

endmodule
